[rtl/core/rrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

    // Request modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ARRAY = 2'd1;
    localparam logic [1:0] MODE_WORDS = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    // Array parse phases
    localparam logic [2:0] PH_COUNT   = 3'd0;
    localparam logic [2:0] PH_DOLLAR  = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;

    // Number field phases
    localparam logic [1:0] NUM_SPACE  = 2'd0;
    localparam logic [1:0] NUM_SIGN   = 2'd1;
    localparam logic [1:0] NUM_DIGITS = 2'd2;
    localparam logic [1:0] NUM_JUNK   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_END_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END_REQ   = 2'd2;

    // Input kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam logic [30:0] MAX_ELEMENTS = 31'd1024;
    localparam logic [34:0] INT_LIMIT    = 35'h07FFFFFFF;

    localparam int OUT_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] token_count;
        logic        last;
    } rrt_entry_t;

    typedef struct packed {
        logic       valid;
        rrt_entry_t entry;
    } rrt_result_t;

endpackage

`default_nettype wire

[rtl/core/rrt_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrt_parser
    import rrt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic        req_type,
    input  wire logic [7:0]  data_byte,
    output rrt_result_t      res0,
    output rrt_result_t      res1
);

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  num_phase_reg, num_phase_next;
    logic        neg_reg, neg_next;
    logic [30:0] value_reg, value_next;
    logic        ovf_reg, ovf_next;
    logic        pcr_reg, pcr_next;
    logic [10:0] elements_reg, elements_next;
    logic [30:0] payload_reg, payload_next;
    logic [1:0]  skip_reg, skip_next;
    logic [15:0] tokens_reg, tokens_next;
    logic        inside_reg, inside_next;

    logic [15:0] tokens_inc;
    assign tokens_inc = (tokens_reg == 16'hFFFF) ? tokens_reg : tokens_reg + 16'd1;

    always_comb begin
        logic        is_digit;
        logic        is_space;
        logic        words_go;
        logic        stop;
        logic        bad;
        logic [1:0]  ph;
        logic [10:0] el;
        logic [30:0] pl;
        logic [1:0]  sk;
        logic [34:0] acc;
        logic        do_arith;

        mode_next      = mode_reg;
        phase_next     = phase_reg;
        num_phase_next = num_phase_reg;
        neg_next       = neg_reg;
        value_next     = value_reg;
        ovf_next       = ovf_reg;
        pcr_next       = pcr_reg;
        elements_next  = elements_reg;
        payload_next   = payload_reg;
        skip_next      = skip_reg;
        tokens_next    = tokens_reg;
        inside_next    = inside_reg;
        res0           = '0;
        res1           = '0;

        is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
        is_space = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
        words_go = 1'b0;
        stop     = 1'b0;
        bad      = 1'b0;
        ph       = num_phase_reg;
        el       = elements_reg - 11'd1;
        pl       = payload_reg - 31'd1;
        sk       = skip_reg - 2'd1;
        do_arith = 1'b0;
        acc      = ({4'd0, value_reg} << 3) + ({4'd0, value_reg} << 1)
                   + {31'd0, data_byte[3:0]};

        if (step_en) begin
            if (req_type == REQ_END) begin
                if (mode_reg == MODE_WORDS && inside_reg) begin
                    res0.valid = 1'b1;
                    res0.entry.kind = KIND_END_TOKEN;
                    res0.entry.token_count = tokens_inc;
                    res1.valid = 1'b1;
                    res1.entry.kind = KIND_END_REQ;
                    res1.entry.token_count = tokens_inc;
                end else begin
                    res0.valid = 1'b1;
                    res0.entry.kind = KIND_END_REQ;
                    res0.entry.token_count = tokens_reg;
                end
                mode_next      = MODE_IDLE;
                phase_next     = PH_COUNT;
                num_phase_next = NUM_SPACE;
                neg_next       = 1'b0;
                value_next     = '0;
                ovf_next       = 1'b0;
                pcr_next       = 1'b0;
                elements_next  = '0;
                payload_next   = '0;
                skip_next      = '0;
                tokens_next    = '0;
                inside_next    = 1'b0;
            end else begin
                unique case (mode_reg)
                    MODE_IDLE: begin
                        if (data_byte == CHAR_STAR) begin
                            mode_next      = MODE_ARRAY;
                            phase_next     = PH_COUNT;
                            num_phase_next = NUM_SPACE;
                            neg_next       = 1'b0;
                            value_next     = '0;
                            ovf_next       = 1'b0;
                            pcr_next       = 1'b0;
                        end else begin
                            mode_next = MODE_WORDS;
                            words_go  = 1'b1;
                        end
                    end
                    MODE_WORDS: words_go = 1'b1;
                    MODE_STOP: ;
                    MODE_ARRAY: begin
                        unique case (phase_reg)
                            PH_COUNT, PH_LENGTH: begin
                                if (pcr_reg && data_byte == CHAR_LF) begin
                                    // line complete: validate the number
                                    pcr_next = 1'b0;
                                    bad = (num_phase_reg == NUM_SPACE)
                                          || (num_phase_reg == NUM_SIGN) || ovf_reg
                                          || (neg_reg && value_reg != '0);
                                    if (bad) begin
                                        mode_next = MODE_STOP;
                                    end else if (phase_reg == PH_COUNT) begin
                                        if (value_reg == '0 || value_reg > MAX_ELEMENTS) begin
                                            mode_next = MODE_STOP;
                                        end else begin
                                            elements_next = value_reg[10:0];
                                            phase_next    = PH_DOLLAR;
                                        end
                                    end else begin
                                        payload_next = value_reg;
                                        if (value_reg == '0) begin
                                            tokens_next   = tokens_inc;
                                            elements_next = el;
                                            if (el == '0) begin
                                                mode_next = MODE_STOP;
                                            end else begin
                                                phase_next = PH_SKIP;
                                                skip_next  = 2'd2;
                                            end
                                            res0.valid = 1'b1;
                                            res0.entry.kind = KIND_END_TOKEN;
                                            res0.entry.token_count = tokens_inc;
                                        end else begin
                                            phase_next = PH_PAYLOAD;
                                        end
                                    end
                                end else begin
                                    // a held CR that is not followed by LF counts as space
                                    if (pcr_reg) begin
                                        pcr_next = 1'b0;
                                        if (ph == NUM_SIGN) begin
                                            stop = 1'b1;
                                        end else if (ph == NUM_DIGITS) begin
                                            ph = NUM_JUNK;
                                        end
                                    end
                                    num_phase_next = ph;
                                    if (stop) begin
                                        mode_next = MODE_STOP;
                                    end else if (data_byte == CHAR_CR) begin
                                        pcr_next = 1'b1;
                                    end else begin
                                        unique case (ph)
                                            NUM_SPACE: begin
                                                if (is_space) begin
                                                    num_phase_next = ph;
                                                end else if (data_byte == CHAR_PLUS
                                                             || data_byte == CHAR_MINUS) begin
                                                    neg_next = (data_byte == CHAR_MINUS);
                                                    num_phase_next = NUM_SIGN;
                                                end else if (!is_digit) begin
                                                    mode_next = MODE_STOP;
                                                end else begin
                                                    num_phase_next = NUM_DIGITS;
                                                    do_arith = 1'b1;
                                                end
                                            end
                                            NUM_SIGN: begin
                                                if (!is_digit) begin
                                                    mode_next = MODE_STOP;
                                                end else begin
                                                    num_phase_next = NUM_DIGITS;
                                                    do_arith = 1'b1;
                                                end
                                            end
                                            NUM_DIGITS: begin
                                                if (!is_digit) begin
                                                    num_phase_next = NUM_JUNK;
                                                end else begin
                                                    do_arith = 1'b1;
                                                end
                                            end
                                            NUM_JUNK: ;
                                        endcase
                                        if (do_arith && !ovf_reg) begin
                                            if (acc > INT_LIMIT) begin
                                                ovf_next = 1'b1;
                                            end else begin
                                                value_next = acc[30:0];
                                            end
                                        end
                                    end
                                end
                            end
                            PH_DOLLAR: begin
                                if (data_byte != CHAR_DOLLAR) begin
                                    mode_next = MODE_STOP;
                                end else begin
                                    num_phase_next = NUM_SPACE;
                                    neg_next       = 1'b0;
                                    value_next     = '0;
                                    ovf_next       = 1'b0;
                                    pcr_next       = 1'b0;
                                    phase_next     = PH_LENGTH;
                                end
                            end
                            PH_PAYLOAD: begin
                                res0.valid = 1'b1;
                                res0.entry.kind = KIND_BYTE;
                                res0.entry.out_byte = data_byte;
                                res0.entry.token_count = tokens_reg;
                                payload_next = pl;
                                if (pl == '0) begin
                                    tokens_next   = tokens_inc;
                                    elements_next = el;
                                    if (el == '0) begin
                                        mode_next = MODE_STOP;
                                    end else begin
                                        phase_next = PH_SKIP;
                                        skip_next  = 2'd2;
                                    end
                                    res1.valid = 1'b1;
                                    res1.entry.kind = KIND_END_TOKEN;
                                    res1.entry.token_count = tokens_inc;
                                end
                            end
                            PH_SKIP: begin
                                skip_next = sk;
                                if (sk == '0) begin
                                    phase_next = PH_DOLLAR;
                                end
                            end
                            default: mode_next = MODE_STOP;
                        endcase
                    end
                endcase

                if (words_go) begin
                    if (is_space) begin
                        if (inside_reg) begin
                            inside_next = 1'b0;
                            tokens_next = tokens_inc;
                            res0.valid = 1'b1;
                            res0.entry.kind = KIND_END_TOKEN;
                            res0.entry.token_count = tokens_inc;
                        end
                    end else begin
                        inside_next = 1'b1;
                        res0.valid = 1'b1;
                        res0.entry.kind = KIND_BYTE;
                        res0.entry.out_byte = data_byte;
                        res0.entry.token_count = tokens_reg;
                    end
                end
            end
        end

        // flag the last result of this item
        if (res1.valid) begin
            res1.entry.last = 1'b1;
        end else if (res0.valid) begin
            res0.entry.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            phase_reg     <= PH_COUNT;
            num_phase_reg <= NUM_SPACE;
            neg_reg       <= 1'b0;
            value_reg     <= '0;
            ovf_reg       <= 1'b0;
            pcr_reg       <= 1'b0;
            elements_reg  <= '0;
            payload_reg   <= '0;
            skip_reg      <= '0;
            tokens_reg    <= '0;
            inside_reg    <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            num_phase_reg <= num_phase_next;
            neg_reg       <= neg_next;
            value_reg     <= value_next;
            ovf_reg       <= ovf_next;
            pcr_reg       <= pcr_next;
            elements_reg  <= elements_next;
            payload_reg   <= payload_next;
            skip_reg      <= skip_next;
            tokens_reg    <= tokens_next;
            inside_reg    <= inside_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/resp_request_tokenizer_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// The first result of an item passes through the input register, then the parse step
// into the output queue, before it can transfer.
// Throughput: one item per cycle while the output queue has room for two results and
// m_tready holds; the four-entry output queue drains one result per cycle.
// Reset (aresetn low, synchronous) empties both registers and returns the parser to idle.

module resp_request_tokenizer_top
    import rrt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] token_count
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    output logic             m_tlast    // out_last
);

    localparam int AW = $clog2(OUT_FIFO_DEPTH);

    logic        in_valid_reg, in_valid_next;
    logic        in_type_reg;
    logic [7:0]  in_data_reg;
    logic        step_en;

    rrt_result_t res0, res1;

    rrt_entry_t  fifo_reg [OUT_FIFO_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW:0]   count_reg, count_next;
    logic          pop;
    logic [AW:0]   push_n;

    // step only with room for two results
    assign step_en  = in_valid_reg && (count_reg <= (AW+1)'(OUT_FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || step_en;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    rrt_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .req_type  (in_type_reg),
        .data_byte (in_data_reg),
        .res0      (res0),
        .res1      (res1)
    );

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {fifo_reg[head_reg].token_count, fifo_reg[head_reg].out_byte};
    assign m_tuser  = fifo_reg[head_reg].kind;
    assign m_tlast  = fifo_reg[head_reg].last;

    assign push_n     = (AW+1)'(res0.valid) + (AW+1)'(res1.valid);
    assign tail_next  = tail_reg + push_n[AW-1:0];
    assign head_next  = pop ? head_reg + AW'(1) : head_reg;
    assign count_next = count_reg + push_n - (AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (res0.valid) begin
            fifo_reg[tail_reg] <= res0.entry;
        end
        if (res1.valid) begin
            fifo_reg[tail_reg + AW'(1)] <= res1.entry;
        end
    end

endmodule

`default_nettype wire
